// File: rtl/minv_pkg.sv
package minv_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int NUM_ELEMS  = 9;
  localparam int NUM_PRODS  = 18;
  localparam int PROD_W     = 2 * ELEM_WIDTH;
  localparam int COF_W      = PROD_W + 1;
  localparam int DET_W      = 3 * ELEM_WIDTH + 2;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t in_r0_c0;
    elem_t in_r1_c0;
    elem_t in_r2_c0;
    elem_t in_r0_c1;
    elem_t in_r1_c1;
    elem_t in_r2_c1;
    elem_t in_r0_c2;
    elem_t in_r1_c2;
    elem_t in_r2_c2;
  } in_item_t;

  typedef struct packed {
    elem_t out_r0_c0;
    elem_t out_r1_c0;
    elem_t out_r2_c0;
    elem_t out_r0_c1;
    elem_t out_r1_c1;
    elem_t out_r2_c1;
    elem_t out_r0_c2;
    elem_t out_r1_c2;
    elem_t out_r2_c2;
    logic  singular;
    logic  saturated;
  } out_item_t;

  // Each cofactor k is PROD_A[2k]*PROD_B[2k] - PROD_A[2k+1]*PROD_B[2k+1].
  localparam logic [3:0] PROD_A [NUM_PRODS] = '{
    4'd4, 4'd7, 4'd7, 4'd1, 4'd1, 4'd4, 4'd6, 4'd3, 4'd0,
    4'd6, 4'd3, 4'd0, 4'd3, 4'd6, 4'd6, 4'd0, 4'd0, 4'd3
  };
  localparam logic [3:0] PROD_B [NUM_PRODS] = '{
    4'd8, 4'd5, 4'd2, 4'd8, 4'd5, 4'd2, 4'd5, 4'd8, 4'd8,
    4'd2, 4'd2, 4'd5, 4'd7, 4'd4, 4'd1, 4'd7, 4'd4, 4'd1
  };

endpackage

// File: rtl/minv_front.sv
module minv_front (
  input  logic                              clk,
  input  logic                              en,
  input  minv_pkg::elem_t                   m   [minv_pkg::NUM_ELEMS],
  output logic signed [minv_pkg::COF_W-1:0] cof [minv_pkg::NUM_ELEMS],
  output logic signed [minv_pkg::DET_W-1:0] det
);

  localparam int E  = minv_pkg::ELEM_WIDTH;
  localparam int CW = minv_pkg::COF_W;
  localparam int DW = minv_pkg::DET_W;
  localparam int NE = minv_pkg::NUM_ELEMS;
  localparam int NP = minv_pkg::NUM_PRODS;

  logic signed [minv_pkg::PROD_W-1:0] p1 [NP];
  minv_pkg::elem_t                    e1 [3];
  minv_pkg::elem_t                    e2 [3];
  logic signed [CW-1:0]               c2 [NE];
  logic signed [CW-1:0]               c3 [NE];
  logic signed [CW-1:0]               c4 [NE];
  logic signed [2*E:0]                pl3 [3];
  logic signed [2*E:0]                ph3 [3];
  logic signed [DW-1:0]               t4 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NP; i++) begin
        p1[i] <= m[minv_pkg::PROD_A[i]] * m[minv_pkg::PROD_B[i]];
      end
      for (int j = 0; j < 3; j++) begin
        e1[j] <= m[3*j];
        e2[j] <= e1[j];
        pl3[j] <= e2[j] * $signed({1'b0, c2[j][E-1:0]});
        ph3[j] <= e2[j] * $signed(c2[j][CW-1:E]);
        t4[j] <= (DW'(ph3[j]) <<< E) + DW'(pl3[j]);
      end
      for (int k = 0; k < NE; k++) begin
        c2[k]  <= CW'(p1[2*k]) - CW'(p1[2*k+1]);
        c3[k]  <= c2[k];
        c4[k]  <= c3[k];
        cof[k] <= c4[k];
      end
      det <= t4[0] + t4[1] + t4[2];
    end
  end

endmodule

// File: rtl/minv_lane.sv
module minv_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [minv_pkg::COF_W-1:0]      cof,
  input  logic        [minv_pkg::DET_W-1:0]      dmag,
  input  logic                                   dneg,
  output logic signed [minv_pkg::ELEM_WIDTH-1:0] q_out,
  output logic                                   sat_out
);

  localparam int E     = minv_pkg::ELEM_WIDTH;
  localparam int CW    = minv_pkg::COF_W;
  localparam int DW    = minv_pkg::DET_W;
  localparam int NUM_W = CW + 2 * FRAC_BITS;
  localparam int SH_W  = DW + E + 2;
  localparam int RW    = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int LAST  = E + 2;

  logic [RW-1:0] r  [0:LAST-1];
  logic [DW-1:0] d  [0:LAST-1];
  logic          qn [0:LAST];
  logic          ov [1:LAST];
  logic [E:0]    q  [1:LAST];

  logic [CW-1:0] mag;
  logic [E:0]    qf;
  logic          pos_over;
  logic          neg_over;
  logic          sat;

  assign mag = cof[CW-1] ? CW'(-cof) : CW'(cof);

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= RW'(mag) << (2 * FRAC_BITS);
      d[0]  <= dmag;
      qn[0] <= cof[CW-1] ^ dneg;
      r[1]  <= r[0];
      d[1]  <= d[0];
      qn[1] <= qn[0];
      ov[1] <= r[0] >= (RW'(d[0]) << (E + 1));
      q[1]  <= '0;
    end
  end

  for (genvar s = 2; s <= LAST; s++) begin : g_step
    localparam int B = LAST - s;
    logic [RW-1:0] sh;
    logic          take;
    assign sh   = RW'(d[s-1]) << B;
    assign take = r[s-1] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        qn[s] <= qn[s-1];
        ov[s] <= ov[s-1];
        q[s]  <= take ? (q[s-1] | ((E+1)'(1) << B)) : q[s-1];
      end
    end
    if (s < LAST) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r[s] <= take ? (r[s-1] - sh) : r[s-1];
          d[s] <= d[s-1];
        end
      end
    end
  end

  assign qf       = q[LAST];
  assign pos_over = qf[E] | qf[E-1];
  assign neg_over = qf[E] | (qf[E-1] & (|qf[E-2:0]));
  assign sat      = ov[LAST] | (qn[LAST] ? neg_over : pos_over);

  always_ff @(posedge clk) begin
    if (en) begin
      sat_out <= sat;
      if (sat) begin
        q_out <= qn[LAST] ? {1'b1, {(E-1){1'b0}}} : {1'b0, {(E-1){1'b1}}};
      end else begin
        q_out <= qn[LAST] ? E'(-qf) : E'(qf);
      end
    end
  end

endmodule

// File: rtl/matrix3_inverse.sv
// Throughput: one transaction per cycle while the output is not stalled; each of the nine divider
// lanes is fully pipelined, with one quotient bit resolved per stage.
// A stalled output freezes the whole pipeline, so the input is stalled in the same cycle.
// Reset (synchronous, active high) clears all valid flags; no clearing pass is needed.
module matrix3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  minv_pkg::in_item_t   in_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  output minv_pkg::out_item_t  out_data,
  output logic                 out_valid,
  input  logic                 out_stall
);

  localparam int E     = minv_pkg::ELEM_WIDTH;
  localparam int CW    = minv_pkg::COF_W;
  localparam int DW    = minv_pkg::DET_W;
  localparam int NE    = minv_pkg::NUM_ELEMS;
  localparam int LANE  = E + 4;
  localparam int VLD_D = 6 + LANE;

  logic                 en;
  minv_pkg::elem_t      m     [NE];
  logic signed [CW-1:0] cof   [NE];
  logic signed [DW-1:0] det;
  logic signed [CW-1:0] cof_p [NE];
  logic [DW-1:0]        dmag;
  logic                 dneg;
  logic                 sing_sr [0:LANE];
  logic                 vld     [VLD_D];
  minv_pkg::elem_t      lane_q  [NE];
  logic [NE-1:0]        lane_sat;
  minv_pkg::elem_t      res     [NE];
  logic                 sing;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign m[0] = in_data.in_r0_c0;
  assign m[1] = in_data.in_r1_c0;
  assign m[2] = in_data.in_r2_c0;
  assign m[3] = in_data.in_r0_c1;
  assign m[4] = in_data.in_r1_c1;
  assign m[5] = in_data.in_r2_c1;
  assign m[6] = in_data.in_r0_c2;
  assign m[7] = in_data.in_r1_c2;
  assign m[8] = in_data.in_r2_c2;

  minv_front u_front (
    .clk (clk),
    .en  (en),
    .m   (m),
    .cof (cof),
    .det (det)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dmag       <= det[DW-1] ? DW'(-det) : DW'(det);
      dneg       <= det[DW-1];
      sing_sr[0] <= (det == '0);
      for (int k = 0; k < NE; k++) begin
        cof_p[k] <= cof[k];
      end
      for (int i = 1; i <= LANE; i++) begin
        sing_sr[i] <= sing_sr[i-1];
      end
    end
  end

  for (genvar k = 0; k < NE; k++) begin : g_lane
    minv_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .cof     (cof_p[k]),
      .dmag    (dmag),
      .dneg    (dneg),
      .q_out   (lane_q[k]),
      .sat_out (lane_sat[k])
    );
  end

  assign sing = sing_sr[LANE];

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      res[k] = sing ? '0 : lane_q[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VLD_D; i++) begin
        vld[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < VLD_D; i++) begin
        vld[i] <= vld[i-1];
      end
      out_valid <= vld[VLD_D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.out_r0_c0 <= res[0];
      out_data.out_r1_c0 <= res[1];
      out_data.out_r2_c0 <= res[2];
      out_data.out_r0_c1 <= res[3];
      out_data.out_r1_c1 <= res[4];
      out_data.out_r2_c1 <= res[5];
      out_data.out_r0_c2 <= res[6];
      out_data.out_r1_c2 <= res[7];
      out_data.out_r2_c2 <= res[8];
      out_data.singular  <= sing;
      out_data.saturated <= !sing && (|lane_sat);
    end
  end

endmodule
